// ===== hdl/stg_pkg.sv =====
// stg_pkg: shared constants, types and the quarter-wave sine table builder
`timescale 1ns / 1ps

package stg_pkg;

  localparam int AUDIO_RATE       = 22050;
  localparam int CHUNK_FRAMES     = 32;
  localparam int PHASE_BITS       = 32;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int MS_PER_SEC       = 1000;

  localparam int SINE_W   = 15;
  localparam int ROM_AW   = 11;
  localparam int IDX_W    = 10;
  localparam int AMP_W    = 15;
  localparam int VOL_W    = 7;
  localparam int FREQ_W   = 14;
  localparam int MS_W     = 16;
  localparam int FRAMES_W = 21;
  localparam int SAMPLE_W = 16;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [VOL_W-1:0]    VOL_MAX         = 7'd100;
  localparam logic [8:0]          AMP_PER_PERCENT = 9'd320;
  localparam logic [AMP_W-1:0]    AMP_RESET       = 15'd16000;
  localparam logic [FREQ_W-1:0]   FREQ_MAX        = 14'(AUDIO_RATE / 2);
  localparam logic [ROM_AW-1:0]   ROM_TOP         = 11'(SINE_TABLE_DEPTH);
  localparam logic [FRAMES_W-1:0] CHUNK_MASK      = 21'(CHUNK_FRAMES - 1);

  // phase step split: 2^32 = STEP_Q * AUDIO_RATE + STEP_R
  localparam logic [17:0] STEP_Q  = 18'((64'd1 << PHASE_BITS) / AUDIO_RATE);
  localparam logic [11:0] STEP_R  = 12'((64'd1 << PHASE_BITS) % AUDIO_RATE);
  localparam logic [14:0] SR_VAL  = 15'(AUDIO_RATE);
  localparam logic [13:0] SR_HALF = 14'(AUDIO_RATE / 2);
  // reciprocal of 1000 scaled by 2^32
  localparam logic [22:0] MS_RECIP = 23'((64'd1 << 32) / MS_PER_SEC);
  localparam logic [9:0]  MS_VAL   = 10'(MS_PER_SEC);

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam int     SERIES_TERMS = 12;
  localparam int     TAB_SHIFT    = $clog2(SINE_TABLE_DEPTH);

  typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  typedef struct packed {
    logic                        valid;
    logic [PHASE_BITS-1:0]       step;
    logic [FRAMES_W-1:0]         frames;
  } stg_load_t;

  // shift and subtract quotient for the non-negative series terms, all below 2^40
  function automatic longint series_div(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 40; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (64'sd1 <<< b);
      end
    end
    return quo;
  endfunction

  // taylor series in q30, rounded to q15
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint    x;
    longint    term;
    longint    sum;
    longint    q15;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (Q30_HALF_PI * longint'(k)) >>> TAB_SHIFT;
      term = x;
      sum  = x;
      for (int n = 1; n < SERIES_TERMS; n++) begin
        term = (term * x) / Q30_ONE;
        term = (term * x) / Q30_ONE;
        term = series_div(term, longint'((2 * n) * (2 * n + 1)));
        if ((n & 1) != 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      q15 = (sum + 64'sd16384) / 64'sd32768;
      if (q15 > 64'sd32767) begin
        q15 = 64'sd32767;
      end
      tab[k] = SINE_W'(q15);
    end
    return tab;
  endfunction

endpackage

// ===== hdl/sine_tone_generator.sv =====
// sine_tone_generator: phase-accumulator sine tone generator top level
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_command, in_freq_hz, in_duration_ms
//  out_     output     out_valid/out_stall  out_sample, out_last
//  cfg_     input      cfg_we               cfg_wdata (volume percent)
//
// a tick beat is taken every cycle that in_stall is low; its sample runs the sine path
// a start beat holds in_stall high while the setup unit works out the phase step
//   and frame count (reciprocal multiply and correction)
// the sine path is input stage, rom read stage and multiply into the output register
// stalls ripple back stage by stage, so bubbles are squeezed out before in_stall rises
// rst_n is synchronous; volume resets to 50 percent and the tone to idle
`timescale 1ns / 1ps

module sine_tone_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [stg_pkg::FREQ_W-1:0]     in_freq_hz,
  input  logic [stg_pkg::MS_W-1:0]       in_duration_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [stg_pkg::SAMPLE_W-1:0] out_sample,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [stg_pkg::VOL_W-1:0]      cfg_wdata
);
  import stg_pkg::*;

  // tone state
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] step_r;
  logic [FRAMES_W-1:0]   frames_r;
  logic                  active_r;
  logic [AMP_W-1:0]      amp_r;

  // sine path
  logic                  s1_valid_r;
  logic [ROM_AW-1:0]     s1_addr_r;
  logic                  s1_neg_r;
  logic                  s1_last_r;
  logic                  s2_valid_r;
  logic                  s2_neg_r;
  logic                  s2_last_r;
  logic                  out_valid_r;
  logic [SAMPLE_W-1:0]   out_sample_r;
  logic                  out_last_r;

  logic                  setup_busy;
  stg_load_t             load;
  logic                  in_accept;
  logic                  start_fire;
  logic                  tick_fire;
  logic                  out_ready;
  logic                  s2_ready;
  logic                  s1_ready;
  logic [1:0]            quad;
  logic [IDX_W-1:0]      idx;
  logic [ROM_AW-1:0]     rom_addr;
  logic [SINE_W-1:0]     rom_data;
  logic [29:0]           mag_prod;
  logic [SAMPLE_W-1:0]   mag;
  logic [VOL_W-1:0]      vol_sat;

  assign out_ready = !out_valid_r || !out_stall;
  assign s2_ready  = !s2_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;

  assign in_stall   = setup_busy || !s1_ready;
  assign in_accept  = in_valid && !in_stall;
  assign start_fire = in_accept && (in_command == CMD_START);
  assign tick_fire  = in_accept && (in_command == CMD_TICK) && active_r;

  stg_tone_setup u_setup (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start_fire),
    .freq_hz     (in_freq_hz),
    .duration_ms (in_duration_ms),
    .busy        (setup_busy),
    .load        (load)
  );

  // quadrant fold onto the quarter-wave table
  assign quad     = phase_r[PHASE_BITS-1 -: 2];
  assign idx      = phase_r[PHASE_BITS-3 -: IDX_W];
  assign rom_addr = quad[0] ? (ROM_TOP - ROM_AW'(idx)) : ROM_AW'(idx);

  assign vol_sat = (cfg_wdata > VOL_MAX) ? VOL_MAX : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r    <= AMP_RESET;
      phase_r  <= '0;
      step_r   <= '0;
      frames_r <= '0;
      active_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        amp_r <= AMP_W'(vol_sat) * AMP_W'(AMP_PER_PERCENT);
      end
      if (load.valid) begin
        phase_r  <= '0;
        step_r   <= load.step;
        frames_r <= load.frames;
        active_r <= (load.frames != '0);
      end else if (tick_fire) begin
        phase_r  <= phase_r + step_r;
        frames_r <= frames_r - FRAMES_W'(1);
        active_r <= (frames_r != FRAMES_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= tick_fire;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_ready) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_addr_r <= rom_addr;
      s1_neg_r  <= quad[1];
      s1_last_r <= (frames_r == FRAMES_W'(1));
    end
    if (s2_ready) begin
      s2_neg_r  <= s1_neg_r;
      s2_last_r <= s1_last_r;
    end
    if (out_ready) begin
      out_sample_r <= s2_neg_r ? (SAMPLE_W'(0) - mag) : mag;
      out_last_r   <= s2_last_r;
    end
  end

  stg_sine_rom u_rom (
    .clk     (clk),
    .en      (s2_ready),
    .addr    (s1_addr_r),
    .rd_data (rom_data)
  );

  // q15 sine times amplitude, truncated toward zero on the magnitude
  assign mag_prod = 30'(rom_data) * 30'(amp_r);
  assign mag      = SAMPLE_W'(mag_prod[29:15]);

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_no_tick_while_setup: assert property (@(posedge clk) disable iff (!rst_n)
    setup_busy |-> !tick_fire)
    else $error("tick beat taken while tone setup busy");

  a_active_has_frames: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (frames_r != '0))
    else $error("tone active with no frames left");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_fire && (frames_r == FRAMES_W'(1))) |=> !active_r)
    else $error("tone still active after final frame");

  a_frames_chunked: assert property (@(posedge clk) disable iff (!rst_n)
    load.valid |-> ((load.frames & CHUNK_MASK) == '0))
    else $error("frame count not a whole number of chunks");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_sample_r) <= 16'sd32000 &&
                     $signed(out_sample_r) >= -16'sd32000))
    else $error("sample outside amplitude range");
`endif

endmodule

// ===== hdl/stg_sine_rom.sv =====
// stg_sine_rom: quarter-wave sine rom with registered read
`timescale 1ns / 1ps

module stg_sine_rom (
  input  logic                       clk,
  input  logic                       en,
  input  logic [stg_pkg::ROM_AW-1:0] addr,
  output logic [stg_pkg::SINE_W-1:0] rd_data
);
  import stg_pkg::*;

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  logic [SINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r <= SINE_TAB[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/stg_tone_setup.sv =====
// stg_tone_setup: multi-cycle phase step and frame count calculation for a start beat
`timescale 1ns / 1ps

module stg_tone_setup (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [stg_pkg::FREQ_W-1:0]   freq_hz,
  input  logic [stg_pkg::MS_W-1:0]     duration_ms,
  output logic                         busy,
  output stg_pkg::stg_load_t           load
);
  import stg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_REM,
    ST_LOAD
  } state_t;

  state_t state_r;

  logic [FREQ_W-1:0]     freq_r;
  logic [MS_W-1:0]       ms_r;
  logic [PHASE_BITS-1:0] hi_r;
  logic [24:0]           x_r;
  logic [30:0]           y_r;
  logic [10:0]           qx_r;
  logic [FRAMES_W-1:0]   qy_r;
  logic [15:0]           rx_r;
  logic [10:0]           ry_r;

  logic [42:0]           prod_x;
  logic [53:0]           prod_y;
  logic [25:0]           qx_sr;
  logic [30:0]           qy_ms;
  logic [FRAMES_W-1:0]   frames_raw;
  logic [FRAMES_W-1:0]   frames_up;

  assign prod_x = 43'(x_r) * 43'(STEP_Q);
  assign prod_y = 54'(y_r) * 54'(MS_RECIP);
  assign qx_sr  = 26'(qx_r) * 26'(SR_VAL);
  assign qy_ms  = 31'(qy_r) * 31'(MS_VAL);

  // reciprocal quotient is low by at most one
  assign frames_raw = qy_r + FRAMES_W'(ry_r >= 11'(MS_VAL));
  assign frames_up  = (frames_raw + CHUNK_MASK) & ~CHUNK_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_MUL;
            freq_r  <= (freq_hz > FREQ_MAX) ? FREQ_MAX : freq_hz;
            ms_r    <= duration_ms;
          end
        end
        ST_MUL: begin
          state_r <= ST_DIV;
          hi_r    <= PHASE_BITS'(freq_r) * PHASE_BITS'(STEP_Q);
          x_r     <= 25'(freq_r) * 25'(STEP_R) + 25'(SR_HALF);
          y_r     <= 31'(ms_r) * 31'(SR_VAL);
        end
        ST_DIV: begin
          state_r <= ST_REM;
          qx_r    <= prod_x[42:32];
          qy_r    <= prod_y[52:32];
        end
        ST_REM: begin
          state_r <= ST_LOAD;
          rx_r    <= 16'(x_r - 25'(qx_sr));
          ry_r    <= 11'(y_r - qy_ms);
        end
        ST_LOAD: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign load.valid  = (state_r == ST_LOAD);
  assign load.step   = hi_r + PHASE_BITS'(qx_r) + PHASE_BITS'(rx_r >= 16'(SR_VAL));
  assign load.frames = frames_up;

endmodule

// ===== bench/tb_sine_tone_generator.sv =====
// tb_sine_tone_generator: self-checking bench for the sine tone generator
`timescale 1ns / 1ps

module tb_sine_tone_generator;

  localparam longint unsigned TONE_RATE = 22050;
  localparam longint unsigned FREQ_CAP  = 11025;
  localparam longint unsigned CHUNK     = 32;
  localparam int SINE_DEPTH      = 1024;
  localparam int AMP_STEP        = 320;
  localparam int VOL_CAP         = 100;
  localparam int VOL_AT_RESET    = 50;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  localparam int NUM_DIRECTED    = 23;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int MAX_TICKS       = 400;
  localparam int SETTLE_CYCLES   = 10;
  localparam int TAIL_CYCLES     = 10;
  localparam int HOLD_CYCLES     = 300;
  localparam int QUIET_LIMIT     = 2000;
  localparam int MAX_PRINTS      = 50;

  typedef struct packed {
    logic signed [stg_pkg::SAMPLE_W-1:0] sample;
    logic                                last;
  } sample_beat_t;

  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_NONE,
    CHECK_VALUE
  } row_check_e;

  typedef struct packed {
    logic                                cmd;
    logic [stg_pkg::FREQ_W-1:0]          freq;
    logic [stg_pkg::MS_W-1:0]            ms;
    row_check_e                          chk;
    logic signed [stg_pkg::SAMPLE_W-1:0] sample;
    logic                                last;
  } directed_row_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic                                in_command;
  logic [stg_pkg::FREQ_W-1:0]          in_freq_hz;
  logic [stg_pkg::MS_W-1:0]            in_duration_ms;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [stg_pkg::SAMPLE_W-1:0] out_sample;
  logic                                out_last;
  logic                                cfg_we;
  logic [stg_pkg::VOL_W-1:0]           cfg_wdata;

  // tone state as the block should hold it
  logic [31:0]               tone_phase;
  logic [31:0]               tone_step;
  logic [20:0]               tone_frames;
  bit                        tone_on;
  logic [stg_pkg::VOL_W-1:0] tone_volume;
  int                        quarter_sine [0:SINE_DEPTH];

  sample_beat_t expected_samples [$];
  int           mismatches;
  int           rx_count;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_NONE,  16'sd0, 1'b0},
    // zero-length tone stays idle
    '{stg_pkg::CMD_START, 14'd0,     16'd0,     CHECK_NONE,  16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_NONE,  16'sd0, 1'b0},
    // frequency saturates to half the rate, longest duration
    '{stg_pkg::CMD_START, 14'd16383, 16'd65535, CHECK_NONE,  16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_VALUE, 16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_VALUE, 16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd16383, 16'd65535, CHECK_VALUE, 16'sd0, 1'b0},
    // restart while playing, just above half the rate
    '{stg_pkg::CMD_START, 14'd11026, 16'd1,     CHECK_NONE,  16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_VALUE, 16'sd0, 1'b0},
    '{stg_pkg::CMD_START, 14'd5513,  16'd2,     CHECK_NONE,  16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_VALUE, 16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_MODEL, 16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_MODEL, 16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_MODEL, 16'sd0, 1'b0},
    // frame count already a whole number of chunks
    '{stg_pkg::CMD_START, 14'd1,     16'd45,    CHECK_NONE,  16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_VALUE, 16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_MODEL, 16'sd0, 1'b0},
    '{stg_pkg::CMD_START, 14'd11024, 16'd1000,  CHECK_NONE,  16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_VALUE, 16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_MODEL, 16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_MODEL, 16'sd0, 1'b0},
    // zero-length restart silences a playing tone
    '{stg_pkg::CMD_START, 14'd0,     16'd0,     CHECK_NONE,  16'sd0, 1'b0},
    '{stg_pkg::CMD_TICK,  14'd0,     16'd0,     CHECK_NONE,  16'sd0, 1'b0}
  };

  sine_tone_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_freq_hz     (in_freq_hz),
    .in_duration_ms (in_duration_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // q15 sine of k quarter-wave steps, taylor series in q30
  function automatic int quarter_sine_q15(input int k);
    longint x;
    longint term;
    longint acc;
    longint rounded;
    x    = (HALF_PI_Q30 * longint'(k)) / longint'(SINE_DEPTH);
    term = x;
    acc  = x;
    for (int n = 1; n < 12; n++) begin
      term = (term * x) / ONE_Q30;
      term = (term * x) / ONE_Q30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rounded = (acc + 16384) / 32768;
    return (rounded > 32767) ? 32767 : int'(rounded);
  endfunction

  function automatic int sine_at(input logic [31:0] ph);
    int         mag;
    logic [9:0] idx;
    idx = ph[29:20];
    mag = ph[30] ? quarter_sine[SINE_DEPTH - int'(idx)] : quarter_sine[idx];
    return ph[31] ? -mag : mag;
  endfunction

  // updates the tone state for one beat; returns 1 when a sample comes out
  function automatic bit advance_tone(input logic cmd, input logic [stg_pkg::FREQ_W-1:0] freq,
                                      input logic [stg_pkg::MS_W-1:0] ms,
                                      output sample_beat_t beat);
    longint unsigned f;
    longint unsigned frames;
    int              s;
    int              q;
    beat = '0;
    if (cmd == stg_pkg::CMD_START) begin
      f           = (freq > FREQ_CAP) ? FREQ_CAP : longint'(freq);
      tone_step   = 32'(((f << 32) + TONE_RATE / 2) / TONE_RATE);
      tone_phase  = '0;
      frames      = (TONE_RATE * longint'(ms)) / 1000;
      frames      = ((frames + CHUNK - 1) / CHUNK) * CHUNK;
      tone_frames = 21'(frames);
      tone_on     = (frames != 0);
      return 1'b0;
    end
    if (!tone_on) begin
      return 1'b0;
    end
    s           = sine_at(tone_phase);
    q           = ((s < 0 ? -s : s) * (int'(tone_volume) * AMP_STEP)) >> 15;
    beat.sample = 16'(s < 0 ? -q : q);
    tone_phase  = tone_phase + tone_step;
    tone_frames = tone_frames - 1'b1;
    tone_on     = (tone_frames != 0);
    beat.last   = (tone_frames == 0);
    return 1'b1;
  endfunction

  function automatic int beat_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch on %0s at sample beat %0d: got %0d, want %0d",
               what, rx_count, got, want);
    end
  endtask

  // drives one beat, waits for it to be taken and predicts what it causes
  task automatic send_beat(input logic cmd, input logic [stg_pkg::FREQ_W-1:0] freq,
                           input logic [stg_pkg::MS_W-1:0] ms, input bit burst,
                           output bit yields, output sample_beat_t beat);
    int gap;
    gap = burst ? 0 : beat_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_freq_hz     <= freq;
    in_duration_ms <= ms;
    do @(posedge clk); while (in_stall);
    yields = advance_tone(cmd, freq, ms, beat);
  endtask

  task automatic offer(input logic cmd, input logic [stg_pkg::FREQ_W-1:0] freq,
                       input logic [stg_pkg::MS_W-1:0] ms, input bit burst,
                       inout int taken);
    bit           yields;
    sample_beat_t beat;
    send_beat(cmd, freq, ms, burst, yields, beat);
    if (yields) begin
      expected_samples.push_back(beat);
    end
    if (cmd == stg_pkg::CMD_START || yields) begin
      taken++;
    end
  endtask

  // mostly a start followed by ticks, sometimes a stray beat
  task automatic play_random_tone(inout int taken);
    bit                         burst;
    int                         roll;
    int                         ticks;
    logic [stg_pkg::FREQ_W-1:0] f;
    logic [stg_pkg::MS_W-1:0]   ms;
    burst = ($urandom_range(0, 9) < 3);
    if ($urandom_range(0, 99) < 8) begin
      offer(1'($urandom_range(0, 1)), 14'($urandom), 16'($urandom), burst, taken);
      return;
    end
    if ($urandom_range(0, 99) < 85) begin
      f = 14'($urandom_range(0, 11025));
    end else begin
      f = 14'($urandom_range(11026, 16383));
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      ms = '0;
    end else if (roll < 70) begin
      ms = 16'($urandom_range(1, 6));
    end else if (roll < 92) begin
      ms = 16'($urandom_range(7, 50));
    end else begin
      ms = 16'($urandom);
    end
    offer(stg_pkg::CMD_START, f, ms, burst, taken);
    // run to the end and a little past, or cut short by the next start
    if ($urandom_range(0, 9) < 6) begin
      ticks = int'(tone_frames) + $urandom_range(0, 2);
    end else begin
      ticks = $urandom_range(0, tone_frames);
    end
    if (ticks > MAX_TICKS) begin
      ticks = MAX_TICKS;
    end
    // stay within the beat budget of this pass
    if (ticks > ITEMS_PER_PHASE - taken) begin
      ticks = ITEMS_PER_PHASE - taken;
    end
    repeat (ticks) offer(stg_pkg::CMD_TICK, 14'($urandom), 16'($urandom), burst, taken);
  endtask

  task automatic set_volume(input logic [stg_pkg::VOL_W-1:0] vol);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= vol;
    @(posedge clk);
    cfg_we      <= 1'b0;
    tone_volume = (vol > VOL_CAP) ? stg_pkg::VOL_W'(VOL_CAP) : vol;
  endtask

  function automatic logic [stg_pkg::VOL_W-1:0] phase_volume(input int ph);
    case (ph)
      0: return 7'd100;
      1: return 7'd0;
      2: return 7'd127;
      3: return 7'd101;
      4: return 7'd1;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin
    directed_row_t row;
    bit            yields;
    sample_beat_t  beat;
    int            taken;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = stg_pkg::CMD_TICK;
    in_freq_hz     = '0;
    in_duration_ms = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    mismatches     = 0;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      quarter_sine[k] = quarter_sine_q15(k);
    end
    tone_phase  = '0;
    tone_step   = '0;
    tone_frames = '0;
    tone_on     = 1'b0;
    tone_volume = stg_pkg::VOL_W'(VOL_AT_RESET);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_rows[i];
      send_beat(row.cmd, row.freq, row.ms, 1'b0, yields, beat);
      case (row.chk)
        CHECK_MODEL: begin
          if (yields) expected_samples.push_back(beat);
        end
        CHECK_VALUE: begin
          expected_samples.push_back(sample_beat_t'{sample: row.sample, last: row.last});
        end
        default: begin
        end
      endcase
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_volume(phase_volume(ph));
      taken = 0;
      while (taken < ITEMS_PER_PHASE) play_random_tone(taken);
    end

    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** sine_tone_generator: PASSED **");
    end else begin
      $display("** sine_tone_generator: FAILED **");
    end
    $finish;
  end

  // sample sink: random stall runs plus one long hold-off to back the block up
  initial begin : sample_sink
    int run;
    bit held;
    out_stall = 1'b0;
    run       = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && rx_count >= 250 && expected_samples.size() > 2) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (run > 0) begin
        run--;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            out_stall <= 1'b0;
            run = $urandom_range(1, 40);
          end
          9: begin
            out_stall <= 1'b1;
            run = $urandom_range(10, 40);
          end
          default: begin
            out_stall <= 1'b1;
            run = $urandom_range(1, 3);
          end
        endcase
      end
    end
  end

  initial begin
    rx_count = 0;
  end

  always @(posedge clk) begin : sample_check
    sample_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected beat, sample", out_sample, 0);
      end else begin
        want = expected_samples.pop_front();
        if (out_sample !== want.sample) begin
          report_mismatch("sample", out_sample, want.sample);
        end
        if (out_last !== want.last) begin
          report_mismatch("last", out_last, want.last);
        end
      end
      rx_count++;
    end
  end

  // ends the run when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("** sine_tone_generator: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/stg_pkg.sv
hdl/stg_sine_rom.sv
hdl/stg_tone_setup.sv
hdl/sine_tone_generator.sv
bench/tb_sine_tone_generator.sv
